// ----- design/stptmc_pkg.sv -----
// ============================================================================
// stptmc_pkg
// Shared types and codes for the stage position tracker and move checker.
// ============================================================================
package stptmc_pkg;

  localparam int unsigned PosW  = 64;
  localparam int unsigned RollW = 32;
  localparam int unsigned CmdW  = 3;
  localparam int unsigned ErrW  = 3;
  localparam int unsigned CfgIdxW = 3;

  localparam int unsigned InDataW  = 200;
  localparam int unsigned OutDataW = 232;

  localparam logic signed [PosW-1:0] PosMax = {1'b0, {(PosW-1){1'b1}}};
  localparam logic signed [PosW-1:0] PosMin = {1'b1, {(PosW-1){1'b0}}};

  typedef enum logic [CmdW-1:0] {
    CMD_TICK      = 3'd0,
    CMD_RELATIVE  = 3'd1,
    CMD_ABSOLUTE  = 3'd2,
    CMD_RETARGET  = 3'd3,
    CMD_SS_REL    = 3'd4,
    CMD_SS_ABS    = 3'd5,
    CMD_CHECK_POS = 3'd6
  } cmd_t;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE         = 3'd0,
    ERR_OUT_TRAVEL   = 3'd1,
    ERR_OUT_SOFT     = 3'd2,
    ERR_INTO_HARD    = 3'd3,
    ERR_POS_SOFT     = 3'd4,
    ERR_OUT_OF_BOUND = 3'd5
  } err_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SYS_POS   = 3'd0,
    REG_SYS_NEG   = 3'd1,
    REG_SOFT_POS  = 3'd2,
    REG_SOFT_NEG  = 3'd3,
    REG_SOFT_EN   = 3'd4,
    REG_HARD_EN   = 3'd5
  } reg_idx_t;

  localparam logic [1:0] PHASE_IDLE  = 2'd0;
  localparam logic [1:0] PHASE_CONST = 2'd1;
  localparam logic signed [1:0] DIR_POS = 2'sd1;
  localparam logic signed [1:0] DIR_NEG = -2'sd1;

  typedef struct packed {
    logic signed [PosW-1:0] sys_pos;
    logic signed [PosW-1:0] sys_neg;
    logic signed [PosW-1:0] soft_pos;
    logic signed [PosW-1:0] soft_neg;
    logic                   soft_en;
    logic                   hard_en;
  } cfg_t;

  typedef struct packed {
    logic [CmdW-1:0]        command;
    logic signed [PosW-1:0] position_increment;
    logic signed [PosW-1:0] move_argument;
    logic [1:0]             trajectory_phase;
    logic signed [1:0]      trajectory_direction;
    logic signed [PosW-1:0] trajectory_target;
    logic                   at_positive_switch;
    logic                   at_negative_switch;
  } item_t;

  typedef struct packed {
    logic                   accepted;
    logic                   deferred;
    logic [ErrW-1:0]        error_code;
    logic signed [PosW-1:0] move_target;
    logic signed [PosW-1:0] move_length;
    logic signed [PosW-1:0] current_position;
    logic [RollW-1:0]       rollover_total;
  } result_t;

endpackage

// ----- design/stptmc_cfg_regs.sv -----
// ============================================================================
// stptmc_cfg_regs
// Limit and enable registers behind the plain write port.
// ============================================================================
module stptmc_cfg_regs
  import stptmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [PosW-1:0]    cfg_wdata,
  output cfg_t               cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_SYS_POS:  cfg_nxt.sys_pos  = cfg_wdata;
        REG_SYS_NEG:  cfg_nxt.sys_neg  = cfg_wdata;
        REG_SOFT_POS: cfg_nxt.soft_pos = cfg_wdata;
        REG_SOFT_NEG: cfg_nxt.soft_neg = cfg_wdata;
        REG_SOFT_EN:  cfg_nxt.soft_en  = cfg_wdata[0];
        REG_HARD_EN:  cfg_nxt.hard_en  = cfg_wdata[0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sys_pos  <= PosMax;
      cfg_r.sys_neg  <= PosMin;
      cfg_r.soft_pos <= PosMax;
      cfg_r.soft_neg <= PosMin;
      cfg_r.soft_en  <= 1'b0;
      cfg_r.hard_en  <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/stptmc_core.sv -----
// ============================================================================
// stptmc_core
// Single-pass tick update, move target/length and limit checks.
// ============================================================================
module stptmc_core
  import stptmc_pkg::*;
(
  input  cfg_t                   cfg,
  input  item_t                  item,
  input  logic signed [PosW-1:0] position,
  input  logic [RollW-1:0]       rollover,
  output logic signed [PosW-1:0] position_nxt,
  output logic [RollW-1:0]       rollover_nxt,
  output result_t                result
);

  logic signed [PosW-1:0] inc;
  logic signed [PosW-1:0] arg;
  logic signed [PosW-1:0] sum;
  logic                   ovf_pos;
  logic                   ovf_neg;
  logic signed [PosW-1:0] target;
  logic signed [PosW-1:0] length;
  logic                   do_check;
  logic                   accepted;
  logic                   deferred;
  logic [ErrW-1:0]        err;
  logic                   same_dir;
  logic signed [PosW-1:0] pos_plus_arg;
  logic signed [PosW-1:0] traj_plus_arg;

  assign inc = item.position_increment;
  assign arg = item.move_argument;
  assign sum = position + inc;

  // Signed overflow of the tick sum, split by direction
  assign ovf_pos = !inc[PosW-1] && (inc != '0) && !position[PosW-1] &&
                   (position != '0) && sum[PosW-1];
  assign ovf_neg = inc[PosW-1] && position[PosW-1] && !sum[PosW-1];

  assign pos_plus_arg  = position + arg;
  assign traj_plus_arg = item.trajectory_target + arg;
  assign same_dir = ((item.trajectory_direction == DIR_POS) && !arg[PosW-1] && (arg != '0)) ||
                    ((item.trajectory_direction == DIR_NEG) && arg[PosW-1]);

  always_comb begin
    position_nxt = position;
    rollover_nxt = rollover;
    target       = '0;
    length       = '0;
    do_check     = 1'b0;
    accepted     = 1'b0;
    deferred     = 1'b0;
    err          = ERR_NONE;
    case (item.command)
      CMD_TICK: begin
        accepted = 1'b1;
        if (ovf_pos) begin
          rollover_nxt = rollover + 1'b1;
          position_nxt = inc - (PosMax - position);
        end else if (ovf_neg) begin
          rollover_nxt = rollover + 1'b1;
          position_nxt = inc + (PosMin - position);
        end else begin
          position_nxt = sum;
        end
      end
      CMD_RELATIVE: begin
        if (item.trajectory_phase == PHASE_IDLE) begin
          target   = pos_plus_arg;
          length   = arg;
          do_check = 1'b1;
        end else if (item.trajectory_phase == PHASE_CONST) begin
          if (same_dir) begin
            target = traj_plus_arg;
            length = traj_plus_arg - position;
          end else begin
            target = pos_plus_arg;
            length = arg;
          end
          do_check = 1'b1;
        end else begin
          accepted = 1'b1;
          deferred = 1'b1;
        end
      end
      CMD_ABSOLUTE: begin
        if (item.trajectory_phase == PHASE_IDLE || item.trajectory_phase == PHASE_CONST) begin
          target   = arg;
          length   = arg - position;
          do_check = 1'b1;
        end else begin
          accepted = 1'b1;
          deferred = 1'b1;
        end
      end
      CMD_RETARGET: begin
        if (item.trajectory_phase == PHASE_CONST) begin
          target   = traj_plus_arg;
          length   = traj_plus_arg - position;
          do_check = 1'b1;
        end else begin
          accepted = 1'b1;
          deferred = 1'b1;
        end
      end
      CMD_SS_REL: begin
        target   = pos_plus_arg;
        length   = arg;
        do_check = 1'b1;
      end
      CMD_SS_ABS: begin
        target   = arg;
        length   = arg - position;
        do_check = 1'b1;
      end
      CMD_CHECK_POS: begin
        target = arg;
        if (cfg.soft_en) begin
          if (arg <= cfg.soft_pos && arg >= cfg.soft_neg) accepted = 1'b1;
          else err = ERR_POS_SOFT;
        end else if (arg <= cfg.sys_pos && arg >= cfg.sys_neg) begin
          accepted = 1'b1;
        end else begin
          err = ERR_OUT_OF_BOUND;
        end
      end
      default: begin
        accepted = 1'b0;
      end
    endcase

    if (do_check) begin
      if (target > cfg.sys_pos || target < cfg.sys_neg) begin
        err = ERR_OUT_TRAVEL;
      end else if (cfg.soft_en && (target < cfg.soft_neg || target > cfg.soft_pos)) begin
        err = ERR_OUT_SOFT;
      end else if (cfg.hard_en &&
                   ((item.at_positive_switch && !length[PosW-1] && (length != '0)) ||
                    (item.at_negative_switch && length[PosW-1]))) begin
        err = ERR_INTO_HARD;
      end else begin
        accepted = 1'b1;
      end
    end
  end

  always_comb begin
    result.accepted         = accepted;
    result.deferred         = deferred;
    result.error_code       = err;
    result.move_target      = target;
    result.move_length      = length;
    result.current_position = position_nxt;
    result.rollover_total   = rollover_nxt;
  end

endmodule

// ----- design/stage_position_tracker_move_checker_top.sv -----
// ============================================================================
// stage_position_tracker_move_checker_top
// Stage position tracker with move and position limit checker.
// ============================================================================
// Path: an accepted input beat passes through the input register, then
// the result register, to its result beat.
// Throughput: one beat per cycle when unstalled; the position update closes
// in the one compute stage, so back-to-back ticks see each other's result.
// Reset (rst_n low, synchronous): position and rollover count clear to zero,
// limits return to the full 64-bit range, both enables clear, pipe empties.
module stage_position_tracker_move_checker_top
  import stptmc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // Input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  // tdata: position_increment[63:0], move_argument[127:64],
  //        trajectory_phase[129:128], trajectory_direction[131:130],
  //        trajectory_target[195:132], at_positive_switch[196],
  //        at_negative_switch[197], zero pad[199:198]
  input  logic [InDataW-1:0]  in_tdata,
  // tuser: command[2:0]
  input  logic [CmdW-1:0]     in_tuser,
  // Result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  // tdata: accepted[0], deferred[1], error_code[4:2], move_target[68:5],
  //        move_length[132:69], current_position[196:133],
  //        rollover_total[228:197], zero pad[231:229]
  output logic [OutDataW-1:0] out_tdata,
  // Configuration write port
  input  logic                cfg_wr_en,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [PosW-1:0]     cfg_wdata
);

  cfg_t cfg;

  stptmc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register stage
  logic  in_valid_r;
  item_t in_item_r;
  logic  advance;      // compute stage hands its beat to the result register
  item_t in_item;

  // Unpack the input beat
  always_comb begin
    in_item.command              = in_tuser;
    in_item.position_increment   = in_tdata[63:0];
    in_item.move_argument        = in_tdata[127:64];
    in_item.trajectory_phase     = in_tdata[129:128];
    in_item.trajectory_direction = in_tdata[131:130];
    in_item.trajectory_target    = in_tdata[195:132];
    in_item.at_positive_switch   = in_tdata[196];
    in_item.at_negative_switch   = in_tdata[197];
  end

  // Result register stage
  logic    out_valid_r;
  result_t out_res_r;

  // Advance when the result slot is empty or being drained this cycle
  assign advance   = !out_valid_r || out_tready;
  // Take a new beat whenever the input slot is empty or moving forward
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r <= in_item;
    end
  end

  // Tracker state
  logic signed [PosW-1:0] position_r;
  logic signed [PosW-1:0] position_nxt;
  logic [RollW-1:0]       rollover_r;
  logic [RollW-1:0]       rollover_nxt;
  result_t                res_nxt;

  stptmc_core u_core (
    .cfg          (cfg),
    .item         (in_item_r),
    .position     (position_r),
    .rollover     (rollover_r),
    .position_nxt (position_nxt),
    .rollover_nxt (rollover_nxt),
    .result       (res_nxt)
  );

  // Commit state only when the beat leaves the compute stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
      rollover_r <= '0;
    end else if (in_valid_r && advance) begin
      position_r <= position_nxt;
      rollover_r <= rollover_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  // Hold the result while the sink stalls
  always_ff @(posedge clk) begin
    if (in_valid_r && advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // Pack the result beat
  always_comb begin
    out_tdata            = '0;
    out_tdata[0]         = out_res_r.accepted;
    out_tdata[1]         = out_res_r.deferred;
    out_tdata[4:2]       = out_res_r.error_code;
    out_tdata[68:5]      = out_res_r.move_target;
    out_tdata[132:69]    = out_res_r.move_length;
    out_tdata[196:133]   = out_res_r.current_position;
    out_tdata[228:197]   = out_res_r.rollover_total;
  end

endmodule
